>>> design/hss_pkg.sv
// Shared types, constants and register codes for the histogram sampling stencil.
// No dependencies; every other design file imports this package.
package hss_pkg;

    localparam int MAX_BINS   = 128;
    localparam int FRAC_BITS  = 24;
    localparam int BIN_W      = $clog2(MAX_BINS);
    localparam int NB_W       = $clog2(MAX_BINS + 1);
    localparam int TABLE_SIZE = MAX_BINS * MAX_BINS;
    localparam int TBL_W      = $clog2(TABLE_SIZE);
    localparam int ADDR_W     = 14;
    localparam int PROB_W     = 25;
    localparam int WORD_W     = 32;
    localparam int IDX_W      = 31;
    // Holds 7^12, the largest digit weight of a 31-bit index
    localparam int DIG_W      = 34;
    localparam int ENT_W      = (PROB_W > FRAC_BITS) ? PROB_W : FRAC_BITS;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int FCNT_W     = $clog2(FRAC_BITS + 1);

    // Divide by 7 through a reciprocal: q = (x * DIV7_MUL) >> DIV7_SHIFT
    localparam logic [31:0] DIV7_MUL   = 32'h9249_2493;
    localparam int          DIV7_SHIFT = 34;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_MIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_INV_DELTA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_MIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_INV_DELTA = 3'd5;

    typedef struct packed {
        logic               grad_mode;
        logic [7:0]         bin_count;
        logic signed [31:0] val_min;
        logic [31:0]        val_inv_delta;
        logic signed [31:0] grad_min;
        logic [31:0]        grad_inv_delta;
    } cfg_t;

    // One queued operation: a table write or a lookup with its threshold
    typedef struct packed {
        logic             kind;
        logic [TBL_W-1:0] addr;
        logic [ENT_W-1:0] data;
    } q_entry_t;

endpackage

>>> design/histogram_sampling_stencil.sv
// Histogram sampling stencil top level: config registers, front end, queue, back end.
// Sequence: a sample passes the front sequencer states MUL, BIN, FLAT, DIG (which runs
// over the base-7 digits of the index, up to 12), FRAC (one step per fraction bit) and
// PUSH, then the queue and table read. The front takes no new transaction during a sample;
// table loads are taken one per cycle while the front is idle and the queue has room.
// Reset: synchronous active-low aresetn clears control and config; table is undefined.
module histogram_sampling_stencil (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [13:0]        s_table_addr,
    input  logic [24:0]        s_table_prob,
    input  logic signed [31:0] s_sample_value,
    input  logic signed [31:0] s_grad_value,
    input  logic [30:0]        s_point_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_selected
);
    import hss_pkg::*;

    cfg_t              cfg_reg;
    logic              q_push, q_pop, q_full, q_empty;
    q_entry_t          q_wdata, q_rdata;
    logic [QCNT_W-1:0] q_count;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grad_mode      <= 1'b0;
            cfg_reg.bin_count      <= 8'd128;
            cfg_reg.val_min        <= '0;
            cfg_reg.val_inv_delta  <= 32'd65536;
            cfg_reg.grad_min       <= '0;
            cfg_reg.grad_inv_delta <= 32'd65536;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GRAD_MODE:      cfg_reg.grad_mode      <= cfg_wdata[0];
                CFG_BIN_COUNT:      cfg_reg.bin_count      <= cfg_wdata[7:0];
                CFG_VAL_MIN:        cfg_reg.val_min        <= cfg_wdata;
                CFG_VAL_INV_DELTA:  cfg_reg.val_inv_delta  <= cfg_wdata;
                CFG_GRAD_MIN:       cfg_reg.grad_min       <= cfg_wdata;
                CFG_GRAD_INV_DELTA: cfg_reg.grad_inv_delta <= cfg_wdata;
                default: ;
            endcase
        end
    end

    hss_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_table_addr   (s_table_addr),
        .s_table_prob   (s_table_prob),
        .s_sample_value (s_sample_value),
        .s_grad_value   (s_grad_value),
        .s_point_index  (s_point_index),
        .q_push         (q_push),
        .q_wdata        (q_wdata),
        .q_full         (q_full)
    );

    hss_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty),
        .count   (q_count)
    );

    hss_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_rdata    (q_rdata),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_selected (m_selected)
    );

    // Queue never overfills and never pushes while full
    a_qcount: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");
    a_qpush: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full))
        else $error("queue push while full");
    // A sample transaction occupies the front sequencer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind == KIND_SAMPLE) |=> !s_ready)
        else $error("front accepted during sample sequence");
    // Pop only from a non-empty queue
    a_qpop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

endmodule

>>> design/hss_front.sv
// Front end: accepts transactions, computes the bin index and the base-7
// radical inverse of a point, and pushes operations into the queue. Uses hss_pkg.
module hss_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  hss_pkg::cfg_t     cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [13:0]       s_table_addr,
    input  logic [24:0]       s_table_prob,
    input  logic signed [31:0] s_sample_value,
    input  logic signed [31:0] s_grad_value,
    input  logic [30:0]       s_point_index,
    output logic              q_push,
    output hss_pkg::q_entry_t q_wdata,
    input  logic              q_full
);
    import hss_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_BIN  = 3'd2;
    localparam logic [2:0] ST_FLAT = 3'd3;
    localparam logic [2:0] ST_DIG  = 3'd4;
    localparam logic [2:0] ST_FRAC = 3'd5;
    localparam logic [2:0] ST_PUSH = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic signed [WORD_W-1:0] val_reg, grad_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [63:0]             vprod_reg, gprod_reg;
    logic                    vpos_reg, gpos_reg;
    logic [BIN_W-1:0]        vbin_reg, gbin_reg;
    logic [TBL_W-1:0]        addr_reg;
    logic [DIG_W:0]          rem_reg;
    logic [DIG_W-1:0]        den_reg;
    logic [FRAC_BITS-1:0]    ri_reg;
    logic [FCNT_W-1:0]       fcnt_reg;

    logic                    accept;
    logic [NB_W-1:0]         nb;
    logic signed [WORD_W:0]  vdiff, gdiff;
    logic [63:0]             idx_prod;
    logic [IDX_W-1:0]        idx_q;
    logic [2:0]              digit;
    logic [DIG_W:0]          rem_sh;
    logic [31:0]             load_addr;
    logic [15:0]             flat;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && !q_full;

    // Effective bin count: zero acts as one, saturate at the table side
    always_comb begin
        if (cfg.bin_count == 8'd0) begin
            nb = NB_W'(1);
        end else if (32'(cfg.bin_count) > MAX_BINS) begin
            nb = NB_W'(MAX_BINS);
        end else begin
            nb = NB_W'(cfg.bin_count);
        end
    end

    assign vdiff = {val_reg[WORD_W-1], val_reg} - {cfg.val_min[WORD_W-1], cfg.val_min};
    assign gdiff = {grad_reg[WORD_W-1], grad_reg} - {cfg.grad_min[WORD_W-1], cfg.grad_min};

    // Digit step: quotient and remainder by 7
    assign idx_prod = 64'(idx_reg) * 64'(DIV7_MUL);
    assign idx_q    = IDX_W'(idx_prod >> DIV7_SHIFT);
    assign digit    = 3'(idx_reg - IDX_W'(idx_q * IDX_W'(7)));
    assign rem_sh   = {rem_reg[DIG_W-1:0], 1'b0};

    assign load_addr = 32'(s_table_addr);
    assign flat = 16'(vbin_reg) * 16'(nb) + 16'(gbin_reg);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && s_kind == KIND_SAMPLE) state_next = ST_MUL;
            ST_MUL:  state_next = ST_BIN;
            ST_BIN:  state_next = ST_FLAT;
            ST_FLAT: state_next = ST_DIG;
            ST_DIG:  if (idx_reg == '0) state_next = ST_FRAC;
            ST_FRAC: if (fcnt_reg == FCNT_W'(FRAC_BITS - 1)) state_next = ST_PUSH;
            ST_PUSH: if (!q_full) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            val_reg  <= s_sample_value;
            grad_reg <= s_grad_value;
            idx_reg  <= s_point_index;
            rem_reg  <= '0;
            den_reg  <= DIG_W'(1);
            fcnt_reg <= '0;
            ri_reg   <= '0;
        end
        if (state_reg == ST_MUL) begin
            vpos_reg  <= (vdiff > 0);
            gpos_reg  <= (gdiff > 0);
            vprod_reg <= 64'(vdiff[WORD_W-1:0]) * 64'(cfg.val_inv_delta);
            gprod_reg <= 64'(gdiff[WORD_W-1:0]) * 64'(cfg.grad_inv_delta);
        end
        if (state_reg == ST_BIN) begin
            if (!vpos_reg) begin
                vbin_reg <= '0;
            end else if (vprod_reg[63:32] >= 32'(nb)) begin
                vbin_reg <= BIN_W'(nb - NB_W'(1));
            end else begin
                vbin_reg <= vprod_reg[32 +: BIN_W];
            end
            if (!gpos_reg) begin
                gbin_reg <= '0;
            end else if (gprod_reg[63:32] >= 32'(nb)) begin
                gbin_reg <= BIN_W'(nb - NB_W'(1));
            end else begin
                gbin_reg <= gprod_reg[32 +: BIN_W];
            end
        end
        if (state_reg == ST_FLAT) begin
            addr_reg <= cfg.grad_mode ? TBL_W'(flat) : TBL_W'(vbin_reg);
        end
        // Reverse the digits while building the weight 7^n
        if (state_reg == ST_DIG && idx_reg != '0) begin
            idx_reg <= idx_q;
            rem_reg <= (rem_reg << 3) - rem_reg + (DIG_W + 1)'(digit);
            den_reg <= (den_reg << 3) - den_reg;
        end
        // Restoring division rev / 7^n, one fraction bit a cycle
        if (state_reg == ST_FRAC) begin
            fcnt_reg <= fcnt_reg + FCNT_W'(1);
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                ri_reg  <= {ri_reg[FRAC_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                ri_reg  <= {ri_reg[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    // Queue write: table loads go straight through, lookups after the sequence
    always_comb begin
        q_push  = 1'b0;
        q_wdata = '0;
        if (state_reg == ST_PUSH) begin
            q_push       = !q_full;
            q_wdata.kind = KIND_SAMPLE;
            q_wdata.addr = addr_reg;
            q_wdata.data = ENT_W'(ri_reg);
        end else if (accept && s_kind == KIND_LOAD && load_addr < TABLE_SIZE) begin
            q_push       = 1'b1;
            q_wdata.kind = KIND_LOAD;
            q_wdata.addr = load_addr[TBL_W-1:0];
            q_wdata.data = ENT_W'(s_table_prob);
        end
    end

endmodule

>>> design/hss_fifo.sv
// Short operation queue between the front and back ends.
// Uses hss_pkg for the entry type and depth.
module hss_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hss_pkg::q_entry_t   wdata,
    output logic                full,
    input  logic                pop,
    output hss_pkg::q_entry_t   rdata,
    output logic                empty,
    output logic [hss_pkg::QCNT_W-1:0] count
);
    import hss_pkg::*;

    q_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rptr_reg];
    assign count = cnt_reg;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= wdata;
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + QPTR_W'(1);
            if (pop)  rptr_reg <= rptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

>>> design/hss_back.sv
// Back end: holds the probability table, applies table writes and turns
// lookups into keep/drop results. Uses hss_pkg.
module hss_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  hss_pkg::q_entry_t q_rdata,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_selected
);
    import hss_pkg::*;

    logic [PROB_W-1:0]    table_mem [TABLE_SIZE];
    logic [PROB_W-1:0]    rd_data_reg;
    logic [FRAC_BITS-1:0] ri_reg;
    logic                 pend_reg;
    logic                 m_valid_reg;
    logic                 sel_reg;
    logic                 rd_en;
    logic                 wr_en;

    // Take the next operation only with the result slot empty
    assign q_pop = !q_empty && !pend_reg && !m_valid_reg;
    assign rd_en = q_pop && q_rdata.kind == KIND_SAMPLE;
    assign wr_en = q_pop && q_rdata.kind == KIND_LOAD;

    always_ff @(posedge aclk) begin
        if (wr_en) table_mem[q_rdata.addr] <= q_rdata.data[PROB_W-1:0];
        if (rd_en) begin
            rd_data_reg <= table_mem[q_rdata.addr];
            ri_reg      <= q_rdata.data[FRAC_BITS-1:0];
        end
    end

    // Compare both values aligned to a common scale
    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            sel_reg <= ({ri_reg, 24'd0} < {rd_data_reg, {FRAC_BITS{1'b0}}});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg <= rd_en;
            if (pend_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_selected = sel_reg;

endmodule
